>>> hdl/mlk_pkg.sv
// Morse letter keyer package: key phase type, ASCII codes and letter tables.
// No dependencies.
package mlk_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_MARK  = 4'b0010,
		PH_GAP   = 4'b0100,
		PH_SPACE = 4'b1000
	} key_phase_t;

	localparam logic [7:0] ASCII_A     = 8'h61;
	localparam logic [7:0] ASCII_Z     = 8'h7A;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	localparam logic [2:0] DOT_UNITS   = 3'd1;
	localparam logic [2:0] DASH_UNITS  = 3'd3;
	localparam logic [2:0] GAP_UNITS   = 3'd1;
	localparam logic [2:0] SPACE_UNITS = 3'd4;

	localparam logic [15:0] TPU_RESET = 16'd250;

	localparam logic REG_TPU = 1'b0;

	// element bits, first element in bit 0, 1 = dash
	function automatic logic [3:0] letter_bits(input logic [4:0] k);
		logic [3:0] b;
		case (k)
			5'd0:  b = 4'd2;   5'd1:  b = 4'd1;   5'd2:  b = 4'd5;
			5'd3:  b = 4'd1;   5'd4:  b = 4'd0;   5'd5:  b = 4'd4;
			5'd6:  b = 4'd3;   5'd7:  b = 4'd0;   5'd8:  b = 4'd0;
			5'd9:  b = 4'd14;  5'd10: b = 4'd5;   5'd11: b = 4'd2;
			5'd12: b = 4'd3;   5'd13: b = 4'd1;   5'd14: b = 4'd7;
			5'd15: b = 4'd6;   5'd16: b = 4'd11;  5'd17: b = 4'd2;
			5'd18: b = 4'd0;   5'd19: b = 4'd1;   5'd20: b = 4'd4;
			5'd21: b = 4'd8;   5'd22: b = 4'd6;   5'd23: b = 4'd9;
			5'd24: b = 4'd13;  5'd25: b = 4'd3;
			default: b = 4'd0;
		endcase
		return b;
	endfunction

	// element count minus one
	function automatic logic [2:0] letter_rest(input logic [4:0] k);
		logic [2:0] n;
		case (k)
			5'd4, 5'd19:                                  n = 3'd0;
			5'd0, 5'd8, 5'd12, 5'd13:                     n = 3'd1;
			5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18,
			5'd20, 5'd22:                                 n = 3'd2;
			default:                                      n = 3'd3;
		endcase
		return n;
	endfunction

endpackage

>>> hdl/mlk_regs.sv
// Morse letter keyer configuration register file, APB-style slave.
// Holds ticks_per_unit. Depends on mlk_pkg.
module mlk_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] ticks_per_unit
);
	import mlk_pkg::*;

	logic [15:0] tpu_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (wr_en && paddr[2] == REG_TPU) begin
			tpu_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TPU: prdata = {16'd0, tpu_q};
			default: prdata = 32'd0;
		endcase
	end

	assign ticks_per_unit = tpu_q;

endmodule

>>> hdl/morse_letter_keyer.sv
// Morse letter keyer top level: input register, keying state and result register.
// Depends on mlk_pkg and mlk_regs.
//
// Each input transaction is either a character load (mode 0) or one time tick
// (mode 1), and each gives exactly one result transaction. One transaction is
// taken every cycle while the result is not stalled. A result is presented when its
// input leaves the input register: the input register feeds the single keying
// state update, whose outcome lands in the result register. A stalled result holds
// the input register, and in_ready drops only while both are full. A unit lasts
// ticks_per_unit tick transactions (0 acts as 1). A dot is 1 unit low, a dash 3,
// each followed by 1 unit high; a space is 4 units high. Loads while busy are
// rejected, bytes other than a..z and space are flagged invalid.
module morse_letter_keyer #(
	parameter int TICK_COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  letter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pin_level,
	output logic        busy_res,
	output logic        rejected,
	output logic        invalid
);
	import mlk_pkg::*;

	localparam int TW   = TICK_COUNTER_WIDTH;
	localparam int CMPW = (TW + 1 > 17) ? TW + 1 : 17;

	logic [15:0] tpu;

	mlk_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.ticks_per_unit (tpu)
	);

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] letter_s1;
	logic       advance;

	logic [3:0]    code_q,  code_d;
	logic [2:0]    elems_q, elems_d;
	key_phase_t    phase_q, phase_d;
	logic [2:0]    units_q, units_d;
	logic [TW-1:0] tick_q,  tick_d;
	logic          pin_q,   pin_d;
	logic          rej_d, inv_d;

	logic            is_letter, is_space;
	logic [4:0]      k;
	logic [CMPW-1:0] tick_next;
	logic [2:0]      units_dec;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1   <= mode;
			letter_s1 <= letter;
		end
	end

	assign is_letter = letter_s1 >= ASCII_A && letter_s1 <= ASCII_Z;
	assign is_space  = letter_s1 == ASCII_SPACE;
	assign k         = 5'(letter_s1 - ASCII_A);
	assign tick_next = CMPW'(tick_q) + CMPW'(1);
	assign units_dec = (units_q != 3'd0) ? units_q - 3'd1 : 3'd0;

	always_comb begin
		code_d  = code_q;
		elems_d = elems_q;
		phase_d = phase_q;
		units_d = units_q;
		tick_d  = tick_q;
		pin_d   = pin_q;
		rej_d   = 1'b0;
		inv_d   = 1'b0;
		if (!mode_s1) begin
			inv_d = !(is_letter || is_space);
			if (phase_q != PH_IDLE) begin
				rej_d = 1'b1;
			end else if (is_letter) begin
				code_d  = letter_bits(k);
				elems_d = letter_rest(k);
				phase_d = PH_MARK;
				units_d = code_d[0] ? DASH_UNITS : DOT_UNITS;
				pin_d   = 1'b0;
				tick_d  = '0;
			end else if (is_space) begin
				phase_d = PH_SPACE;
				units_d = SPACE_UNITS;
				pin_d   = 1'b1;
				tick_d  = '0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (tick_next >= CMPW'(tpu) || tick_q == {TW{1'b1}}) begin
				tick_d  = '0;
				units_d = units_dec;
				if (units_dec == 3'd0) begin
					if (phase_q == PH_MARK) begin
						phase_d = PH_GAP;
						units_d = GAP_UNITS;
						pin_d   = 1'b1;
					end else if (phase_q == PH_GAP && elems_q != 3'd0) begin
						code_d  = {1'b0, code_q[3:1]};
						elems_d = elems_q - 3'd1;
						phase_d = PH_MARK;
						units_d = code_q[1] ? DASH_UNITS : DOT_UNITS;
						pin_d   = 1'b0;
					end else begin
						phase_d = PH_IDLE;
						code_d  = 4'd0;
						elems_d = 3'd0;
						pin_d   = 1'b1;
					end
				end
			end else begin
				tick_d = tick_next[TW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= 4'd0;
			elems_q <= 3'd0;
			phase_q <= PH_IDLE;
			units_q <= 3'd0;
			tick_q  <= '0;
			pin_q   <= 1'b1;
		end else if (advance) begin
			code_q  <= code_d;
			elems_q <= elems_d;
			phase_q <= phase_d;
			units_q <= units_d;
			tick_q  <= tick_d;
			pin_q   <= pin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_level <= pin_d;
			busy_res  <= phase_d != PH_IDLE;
			rejected  <= rej_d;
			invalid   <= inv_d;
		end
	end

	a_idle_pin_high: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> pin_q)
		else $error("pin low while idle");

	a_mark_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MARK |-> !pin_q)
		else $error("pin high during mark");

	a_busy_units: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> units_q != 3'd0)
		else $error("busy with no units left");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(tick_q))
		else $error("state moved without a transaction");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

>>> tb/testbench.sv
// Testbench for morse_letter_keyer: valid/ready driver and monitor with a keying predictor.
// Register writes and read-back go through the APB port; types and codes come from mlk_pkg.
// Depends on mlk_pkg and the morse_letter_keyer RTL.
`timescale 1ns / 100ps

module testbench;
	import mlk_pkg::*;

	localparam int TCW = 16;
	localparam logic [2:0] ADDR_TPU = 3'(4 * int'(REG_TPU));
	localparam logic [15:0] TPU_AFTER_RESET = 16'd250;
	localparam logic TICK = 1'b1;
	localparam logic LOAD = 1'b0;

	typedef struct packed {
		logic       mode;
		logic [7:0] letter;
		logic [1:0] gap;
		logic       hurry;
	} key_txn_t;

	typedef struct packed {
		logic pin;
		logic busy;
		logic rej;
		logic inv;
		logic hurry;
	} key_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [7:0]  letter = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        pin_level;
	logic        busy_res;
	logic        rejected;
	logic        invalid;

	key_txn_t    key_txn_q[$];
	key_result_t expected_keying[$];
	int          fault_count = 0;
	logic        hurry_cur = 1'b0;

	// predictor state
	logic [15:0]    tpu_cfg = TPU_AFTER_RESET;
	logic [3:0]     pattern = '0;
	logic [2:0]     elems_left = '0;
	key_phase_t     phase = PH_IDLE;
	logic [2:0]     units_left = '0;
	logic [TCW-1:0] tick_cnt = '0;
	logic           pin = 1'b1;

	morse_letter_keyer #(.TICK_COUNTER_WIDTH(TCW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .letter(letter),
		.out_valid(out_valid), .out_ready(out_ready),
		.pin_level(pin_level), .busy_res(busy_res), .rejected(rejected), .invalid(invalid)
	);

	always #10 clk = ~clk;

	function automatic string morse_glyph(input logic [4:0] k);
		case (k)
			5'd0:  return ".-";    5'd1:  return "-...";  5'd2:  return "-.-.";
			5'd3:  return "-..";   5'd4:  return ".";     5'd5:  return "..-.";
			5'd6:  return "--.";   5'd7:  return "....";  5'd8:  return "..";
			5'd9:  return ".---";  5'd10: return "-.-";   5'd11: return ".-..";
			5'd12: return "--";    5'd13: return "-.";    5'd14: return "---";
			5'd15: return ".--.";  5'd16: return "--.-";  5'd17: return ".-.";
			5'd18: return "...";   5'd19: return "-";     5'd20: return "..-";
			5'd21: return "...-";  5'd22: return ".--";   5'd23: return "-..-";
			5'd24: return "-.--";  default: return "--..";
		endcase
	endfunction

	function automatic void begin_element();
		phase = PH_MARK;
		units_left = pattern[0] ? DASH_UNITS : DOT_UNITS;
		pin = 1'b0;
		tick_cnt = '0;
	endfunction

	function automatic void close_unit();
		if (units_left != 0)
			units_left = units_left - 1'b1;
		if (units_left == 0) begin
			if (phase == PH_MARK) begin
				phase = PH_GAP;
				units_left = GAP_UNITS;
				pin = 1'b1;
			end else if (phase == PH_GAP && elems_left != 0) begin
				pattern = pattern >> 1;
				elems_left = elems_left - 1'b1;
				begin_element();
			end else begin
				phase = PH_IDLE;
				pattern = '0;
				elems_left = '0;
				pin = 1'b1;
			end
		end
	endfunction

	function automatic key_result_t key_step(input logic m, input logic [7:0] ch, input logic h);
		key_result_t r;
		logic        is_letter;
		logic        is_space;
		string       g;
		r = '0;
		if (m == LOAD) begin
			is_letter = (ch >= ASCII_A && ch <= ASCII_Z);
			is_space = (ch == ASCII_SPACE);
			r.inv = !(is_letter || is_space);
			if (phase != PH_IDLE) begin
				r.rej = 1'b1;
			end else if (is_letter) begin
				g = morse_glyph(5'(ch - ASCII_A));
				pattern = '0;
				for (int i = 0; i < g.len(); i++)
					if (g[i] == "-")
						pattern[i] = 1'b1;
				elems_left = 3'(g.len() - 1);
				begin_element();
			end else if (is_space) begin
				phase = PH_SPACE;
				units_left = SPACE_UNITS;
				pin = 1'b1;
				tick_cnt = '0;
			end
		end else if (phase != PH_IDLE) begin
			if (longint'(tick_cnt) + 1 >= longint'(tpu_cfg) || &tick_cnt) begin
				tick_cnt = '0;
				close_unit();
			end else begin
				tick_cnt = tick_cnt + 1'b1;
			end
		end
		r.pin = pin;
		r.busy = (phase != PH_IDLE);
		r.hurry = h;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		int       tx_wait;
		key_txn_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait = 0;
		end else begin
			if (in_valid && in_ready)
				expected_keying.push_back(key_step(mode, letter, hurry_cur));
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					tx_wait = tx_wait - 1;
					in_valid <= 1'b0;
				end else if (key_txn_q.size() != 0) begin
					nxt = key_txn_q.pop_front();
					in_valid <= 1'b1;
					mode <= nxt.mode;
					letter <= nxt.letter;
					hurry_cur <= nxt.hurry;
					tx_wait = nxt.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : watch
		int          stall_n;
		key_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_n = 0;
		end else if (out_valid && out_ready) begin
			stall_n = 0;
			if (expected_keying.size() == 0) begin
				$display("%0t result with none expected: pin %b busy %b rej %b inv %b",
					$time, pin_level, busy_res, rejected, invalid);
				fault_count++;
			end else begin
				e = expected_keying.pop_front();
				if (pin_level !== e.pin) begin
					$display("%0t pin_level expected %b actual %b", $time, e.pin, pin_level);
					fault_count++;
				end
				if (busy_res !== e.busy) begin
					$display("%0t busy_res expected %b actual %b", $time, e.busy, busy_res);
					fault_count++;
				end
				if (rejected !== e.rej) begin
					$display("%0t rejected expected %b actual %b", $time, e.rej, rejected);
					fault_count++;
				end
				if (invalid !== e.inv) begin
					$display("%0t invalid expected %b actual %b", $time, e.inv, invalid);
					fault_count++;
				end
				stall_n = e.hurry ? 0 : $urandom_range(0, 3);
			end
			out_ready <= (stall_n == 0);
		end else if (stall_n != 0) begin
			stall_n = stall_n - 1;
			out_ready <= (stall_n == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_item(input logic m, input logic [7:0] ch, input logic h);
		key_txn_t t;
		t.mode = m;
		t.letter = ch;
		t.gap = h ? 2'd0 : 2'($urandom_range(0, 3));
		t.hurry = h;
		key_txn_q.push_back(t);
	endtask

	task automatic push_ticks(input int n, input logic h);
		for (int i = 0; i < n; i++)
			push_item(TICK, 8'($urandom), h);
	endtask

	task automatic drain();
		while (key_txn_q.size() != 0 || in_valid || expected_keying.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_read(input logic [15:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_TPU;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {16'h0000, want}) begin
			$display("%0t ticks_per_unit read expected %h actual %h", $time, want, prdata);
			fault_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TPU;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tpu_cfg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_read(value);
	endtask

	initial begin : stimulus
		logic       h;
		logic [7:0] ch;
		int         sel;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the unit length: a dot ends after 250 ticks
		cfg_read(TPU_AFTER_RESET);
		push_item(LOAD, "e", 1'b1);
		push_ticks(255, 1'b1);
		drain();

		cfg_write(16'd1);
		push_item(TICK, 8'hFF, 1'b0);
		push_item(LOAD, ASCII_A, 1'b0);
		push_item(LOAD, "b", 1'b0);
		push_item(LOAD, 8'hFF, 1'b0);
		push_ticks(3, 1'b0);
		push_item(LOAD, ASCII_SPACE, 1'b0);
		push_ticks(4, 1'b0);
		push_item(LOAD, ASCII_Z, 1'b0);
		push_ticks(13, 1'b0);
		push_item(LOAD, ASCII_SPACE, 1'b0);
		push_ticks(5, 1'b0);
		push_item(LOAD, 8'h00, 1'b0);
		push_item(LOAD, 8'h60, 1'b0);
		push_item(LOAD, 8'h7B, 1'b0);
		push_item(LOAD, 8'h1F, 1'b0);
		push_item(LOAD, 8'h21, 1'b0);
		drain();

		// zero acts as one tick per unit
		cfg_write(16'd0);
		push_item(LOAD, "t", 1'b0);
		push_ticks(4, 1'b0);
		push_item(LOAD, "q", 1'b0);
		push_ticks(16, 1'b0);
		drain();

		// longest unit: a dot held low, then a load while busy
		cfg_write(16'hFFFF);
		push_item(LOAD, "e", 1'b1);
		push_ticks(20, 1'b1);
		push_item(LOAD, 8'h80, 1'b1);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 0)
				cfg_write(16'd1);
			else if (p == 5)
				cfg_write(16'd7);
			else
				cfg_write(16'($urandom_range(1, 4)));
			h = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 60; i++) begin
				if ($urandom_range(0, 99) < 12) begin
					sel = $urandom_range(0, 9);
					if (sel < 7)
						ch = 8'(ASCII_A + $urandom_range(0, 25));
					else if (sel == 7)
						ch = ASCII_SPACE;
					else
						ch = 8'($urandom);
					push_item(LOAD, ch, h);
				end else begin
					push_item(TICK, 8'($urandom), h);
				end
			end
			drain();
		end

		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#100000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
